/* hw/rtl/conv3x3_image_filter_assert.svh */
// Assertion macros used by the 3x3 image filter RTL.
`ifndef CONV3X3_IMAGE_FILTER_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define C3F_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("c3f assertion failed");
// Consequent that must hold in the same cycle as the antecedent.
`define C3F_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("c3f assertion failed");
// Consequent that must hold in the cycle after the antecedent.
`define C3F_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("c3f assertion failed");
`else
`define C3F_ASSERT_ALWAYS(label, cond)
`define C3F_ASSERT_IMPL(label, ante, cons)
`define C3F_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/c3f_pkg.sv */
// Types, constants and kernel coefficients of the 3x3 image filter.
`default_nettype none

package c3f_pkg;

	// Fixed arithmetic widths.
	localparam int COEF_FRAC_BITS = 12;
	localparam int COEF_W         = 17;
	localparam int PROD_W         = 26;
	localparam int SUM_W          = 28;
	localparam int DIM_W          = 14;
	localparam int POS_W          = 11;
	localparam int PIX_W          = 24;
	localparam int LANE_W         = 8;
	localparam int LANES          = 3;
	localparam int TAPS           = 9;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PTR_W = 4;
	localparam int FIFO_CNT_W = 5;

	// Frame size after reset.
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Configuration register indices.
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_IMAGE_WIDTH   = 2'd0;
	localparam cfg_index_t CFG_IMAGE_HEIGHT  = 2'd1;
	localparam cfg_index_t CFG_FILTER_SELECT = 2'd2;

	// Kernel codes; the two unused codes behave as identity.
	typedef logic [2:0] filter_code_t;
	localparam filter_code_t FILT_IDENTITY = 3'd0;
	localparam filter_code_t FILT_SMOOTH   = 3'd1;
	localparam filter_code_t FILT_BLUR     = 3'd2;
	localparam filter_code_t FILT_SHARPEN  = 3'd3;
	localparam filter_code_t FILT_MEAN     = 3'd4;
	localparam filter_code_t FILT_EMBOSS   = 3'd5;

	// Window tap positions, top row first, newest column last.
	typedef logic [3:0] tap_t;
	localparam tap_t TAP_NW = 4'd0;
	localparam tap_t TAP_N  = 4'd1;
	localparam tap_t TAP_NE = 4'd2;
	localparam tap_t TAP_W  = 4'd3;
	localparam tap_t TAP_C  = 4'd4;
	localparam tap_t TAP_E  = 4'd5;
	localparam tap_t TAP_SW = 4'd6;
	localparam tap_t TAP_S  = 4'd7;
	localparam tap_t TAP_SE = 4'd8;

	typedef logic signed [COEF_W-1:0] coef_t;

	// Coefficients in fixed point, rounded to nearest.
	localparam int   Q_UNIT         = 1 << COEF_FRAC_BITS;
	localparam coef_t Q_ONE          = coef_t'(Q_UNIT);
	localparam coef_t Q_NINTH        = coef_t'((Q_UNIT + 4) / 9);
	localparam coef_t Q_SIXTEENTH    = coef_t'((Q_UNIT + 8) / 16);
	localparam coef_t Q_EIGHTH       = coef_t'((2 * Q_UNIT + 8) / 16);
	localparam coef_t Q_QUARTER      = coef_t'((4 * Q_UNIT + 8) / 16);
	localparam coef_t Q_TWO_THIRDS   = coef_t'((2 * Q_UNIT + 1) / 3);
	localparam coef_t Q_ELEVEN_THIRD = coef_t'((11 * Q_UNIT + 1) / 3);
	localparam coef_t Q_NINE         = coef_t'(9 * Q_UNIT);

	// A lane sum at or above this value saturates to full scale.
	localparam logic signed [SUM_W-1:0] SAT_LIMIT = SUM_W'(256 << COEF_FRAC_BITS);

	// Position and pixel data that travel with an item through the pipeline.
	typedef struct packed {
		logic [POS_W-1:0] row_int;
		logic [POS_W-1:0] col_int;
		logic [POS_W-1:0] row_brd;
		logic [POS_W-1:0] col_brd;
		logic [PIX_W-1:0] px;
		logic             has_int;
		logic             has_brd;
	} meta_t;

	// One entry of the result queue.
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [PIX_W-1:0] pix;
		logic             last;
	} result_t;

	// Coefficient of one tap of the selected kernel.
	function automatic coef_t kernel_coef(filter_code_t sel, tap_t tap);
		coef_t c;
		c = '0;
		case (sel)
			FILT_SMOOTH: c = Q_NINTH;
			FILT_BLUR: begin
				if (tap == TAP_C)
					c = Q_QUARTER;
				else if (tap == TAP_NW || tap == TAP_NE || tap == TAP_SW || tap == TAP_SE)
					c = Q_SIXTEENTH;
				else
					c = Q_EIGHTH;
			end
			FILT_SHARPEN: begin
				if (tap == TAP_C)
					c = Q_ELEVEN_THIRD;
				else if (tap == TAP_N || tap == TAP_W || tap == TAP_E || tap == TAP_S)
					c = -Q_TWO_THIRDS;
			end
			FILT_MEAN: c = (tap == TAP_C) ? Q_NINE : -Q_ONE;
			FILT_EMBOSS: begin
				if (tap == TAP_N)
					c = Q_ONE;
				else if (tap == TAP_S)
					c = -Q_ONE;
			end
			default: c = (tap == TAP_C) ? Q_ONE : '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/conv3x3_image_filter.sv */
// 3x3 convolution filter over a raster-order RGB pixel stream.
// Results of an item pass the line store read, window, product and row-sum registers before the result queue.
// One item is accepted per cycle while reservations leave room for two more in the 16-entry result queue.
// An item on the last row or column that completes an interior pixel gives two results.
// Line stores are simple dual-port memories: read on acceptance, written back in the cycle after.
// Reset clears counters, queue and window and loads 640 x 480, identity; line stores hold junk.
`default_nettype none
`include "conv3x3_image_filter_assert.svh"

module conv3x3_image_filter
	import c3f_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [11:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        pix_red,
	input  wire logic [7:0]        pix_green,
	input  wire logic [7:0]        pix_blue,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [10:0]            out_row,
	output logic [10:0]            out_col,
	output logic [7:0]             res_red,
	output logic [7:0]             res_green,
	output logic [7:0]             res_blue,
	output logic                   last_of_run
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	// Configuration and frame position.
	logic [DIM_W-1:0] wm1_q, hm1_q;
	filter_code_t     filt_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             accept;
	logic             size_write;
	logic             at_last_col, at_last_row;
	logic [DIM_W-1:0] cfg_dim;
	logic [DIM_W-1:0] clamp_w, clamp_h;
	meta_t            meta_in;

	// Pipeline.
	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	meta_t            meta_s1, meta_s2, meta_s3, meta_s4;
	logic [COL_W-1:0] addr_s1;
	logic [PIX_W-1:0] up_rd_s1, lo_rd_s1;
	logic [PIX_W-1:0] window_q [TAPS];
	logic signed [PROD_W-1:0] prod_d [LANES][TAPS];
	logic signed [PROD_W-1:0] prod_s3 [LANES][TAPS];
	logic signed [SUM_W-1:0]  part_d [LANES][3];
	logic signed [SUM_W-1:0]  part_s4 [LANES][3];
	logic signed [SUM_W-1:0]  total [LANES];
	logic [PIX_W-1:0]         filtered;

	// Line store memories.
	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

	// Result queue.
	result_t               fifo_mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fifo_cnt_q, reserved_q;
	logic [1:0]            n_acc, n_push;
	logic                  pop;
	result_t               int_entry, brd_entry, head;

	// Handshake and result counts per item.
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;
	assign in_ready = reserved_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = fifo_cnt_q != '0;

	// A write to either size register restarts the frame.
	assign size_write = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	assign at_last_col = DIM_W'(col_q) == wm1_q;
	assign at_last_row = DIM_W'(row_q) == hm1_q;

	// Classify the arriving pixel by its place in the frame.
	always_comb begin
		meta_in.row_int = POS_W'(row_q) - POS_W'(1);
		meta_in.col_int = POS_W'(col_q) - POS_W'(1);
		meta_in.row_brd = POS_W'(row_q);
		meta_in.col_brd = POS_W'(col_q);
		meta_in.px      = {pix_blue, pix_green, pix_red};
		meta_in.has_int = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		meta_in.has_brd = (row_q == '0) || (col_q == '0) || at_last_row || at_last_col;
	end

	assign n_acc  = accept ? ({1'b0, meta_in.has_int} + {1'b0, meta_in.has_brd}) : 2'd0;
	assign n_push = valid_s4 ? ({1'b0, meta_s4.has_int} + {1'b0, meta_s4.has_brd}) : 2'd0;

	// Clamp a written frame size into the supported range.
	always_comb begin
		cfg_dim = DIM_W'(cfg_data);
		clamp_w = cfg_dim;
		clamp_h = cfg_dim;
		if (cfg_dim < DIM_W'(3)) begin
			clamp_w = DIM_W'(3);
			clamp_h = DIM_W'(3);
		end else begin
			if (cfg_dim > DIM_W'(MAX_WIDTH))
				clamp_w = DIM_W'(MAX_WIDTH);
			if (cfg_dim > DIM_W'(MAX_HEIGHT))
				clamp_h = DIM_W'(MAX_HEIGHT);
		end
	end

	// Configuration registers and the raster counters; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q  <= DIM_W'(RST_W - 1);
			hm1_q  <= DIM_W'(RST_H - 1);
			filt_q <= FILT_IDENTITY;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			if (size_write) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : ROW_W'(row_q + 1'b1);
				end else begin
					col_q <= COL_W'(col_q + 1'b1);
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH: wm1_q <= clamp_w - DIM_W'(1);
					CFG_IMAGE_HEIGHT: hm1_q <= clamp_h - DIM_W'(1);
					CFG_FILTER_SELECT: filt_q <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

	// Line stores: read the column on acceptance, write it back in the following cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1 <= upper_mem[col_q];
			lo_rd_s1 <= lower_mem[col_q];
		end
		if (valid_s1) begin
			upper_mem[addr_s1] <= lo_rd_s1;
			lower_mem[addr_s1] <= meta_s1.px;
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Item data travelling alongside the arithmetic.
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_in;
			addr_s1 <= col_q;
		end
		if (valid_s1)
			meta_s2 <= meta_s1;
		if (valid_s2)
			meta_s3 <= meta_s2;
		if (valid_s3)
			meta_s4 <= meta_s3;
	end

	// The 3x3 window shifts left and takes in the new column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				window_q[i] <= '0;
		end else if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i * 3]     <= window_q[i * 3 + 1];
				window_q[i * 3 + 1] <= window_q[i * 3 + 2];
			end
			window_q[2] <= up_rd_s1;
			window_q[5] <= lo_rd_s1;
			window_q[8] <= meta_s1.px;
		end
	end

	// One constant-coefficient product per tap and lane.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			for (int t = 0; t < TAPS; t++) begin
				prod_d[l][t] = PROD_W'($signed({1'b0, window_q[t][l * LANE_W +: LANE_W]}))
					* PROD_W'(kernel_coef(filt_q, tap_t'(t)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2)
			prod_s3 <= prod_d;
	end

	// Partial sums, one per window row.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			for (int r = 0; r < 3; r++) begin
				part_d[l][r] = SUM_W'(prod_s3[l][r * 3]) + SUM_W'(prod_s3[l][r * 3 + 1])
					+ SUM_W'(prod_s3[l][r * 3 + 2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3)
			part_s4 <= part_d;
	end

	// Final sum, scaling and saturation to 0..255.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			total[l] = part_s4[l][0] + part_s4[l][1] + part_s4[l][2];
			if (total[l] <= 0)
				filtered[l * LANE_W +: LANE_W] = '0;
			else if (total[l] >= SAT_LIMIT)
				filtered[l * LANE_W +: LANE_W] = '1;
			else
				filtered[l * LANE_W +: LANE_W] = total[l][COEF_FRAC_BITS +: LANE_W];
		end
	end

	// Queue entries: the interior result precedes the border copy.
	always_comb begin
		int_entry.row  = meta_s4.row_int;
		int_entry.col  = meta_s4.col_int;
		int_entry.pix  = filtered;
		int_entry.last = !meta_s4.has_brd;
		brd_entry.row  = meta_s4.row_brd;
		brd_entry.col  = meta_s4.col_brd;
		brd_entry.pix  = meta_s4.px;
		brd_entry.last = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			if (meta_s4.has_int)
				fifo_mem[wr_ptr_q] <= int_entry;
			if (meta_s4.has_brd)
				fifo_mem[meta_s4.has_int ? FIFO_PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q] <= brd_entry;
		end
	end

	// Queue pointers, fill level and the reservation made at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			reserved_q <= '0;
		end else begin
			wr_ptr_q   <= FIFO_PTR_W'(wr_ptr_q + n_push);
			rd_ptr_q   <= FIFO_PTR_W'(rd_ptr_q + pop);
			fifo_cnt_q <= FIFO_CNT_W'(fifo_cnt_q + n_push - pop);
			reserved_q <= FIFO_CNT_W'(reserved_q + n_acc - pop);
		end
	end

	// Output port.
	assign head        = fifo_mem[rd_ptr_q];
	assign out_row     = head.row;
	assign out_col     = head.col;
	assign res_red     = head.pix[7:0];
	assign res_green   = head.pix[15:8];
	assign res_blue    = head.pix[23:16];
	assign last_of_run = head.last;

	// The line store read never meets the write-back of the same column.
	`C3F_ASSERT_IMPL(a_no_rw_collision, accept && valid_s1, col_q != addr_s1)
	// Queue contents never exceed what acceptance reserved.
	`C3F_ASSERT_ALWAYS(a_fifo_within_reserve, fifo_cnt_q <= reserved_q)
	`C3F_ASSERT_ALWAYS(a_reserve_bound, reserved_q <= FIFO_CNT_W'(FIFO_DEPTH))
	// A size write returns the frame to its first pixel.
	`C3F_ASSERT_NEXT(a_size_write_restarts, size_write, col_q == '0 && row_q == '0)

endmodule

`default_nettype wire

/* verif/conv3x3_image_filter_tb.sv */
// Self-checking testbench for the 3x3 image filter: directed table, wide, tall and random frames.
`default_nettype none

module conv3x3_image_filter_tb;
	import c3f_pkg::*;

	// Run limits and predictor constants.
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SETTLE_LIMIT = 5000;
	localparam int PIPE_SLACK   = 8;
	localparam int RANDOM_ITEMS = 160;
	localparam int WIDE_ITEMS   = 32;
	localparam int TALL_ITEMS   = 32;
	localparam int FRAME_MAX    = 2048;
	localparam int K_FRAC       = 12;
	localparam int K_UNIT       = 1 << K_FRAC;
	localparam int K_NINTH      = (K_UNIT + 4) / 9;
	localparam int K_SIXTEENTH  = (K_UNIT + 8) / 16;
	localparam int K_EIGHTH     = (2 * K_UNIT + 8) / 16;
	localparam int K_QUARTER    = (4 * K_UNIT + 8) / 16;
	localparam int K_TWO_THIRDS = (2 * K_UNIT + 1) / 3;
	localparam int K_ELEVEN_3RD = (11 * K_UNIT + 1) / 3;
	localparam int K_NINE       = 9 * K_UNIT;

	// Codes the package leaves unnamed.
	localparam filter_code_t FILT_SPARE_LO = 3'd6;
	localparam filter_code_t FILT_SPARE_HI = 3'd7;
	localparam cfg_index_t   CFG_UNUSED    = 2'd3;

	typedef struct packed {
		logic [10:0] row;
		logic [10:0] col;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
	} out_pixel_t;

	typedef enum logic {DIR_PIXEL, DIR_WRITE} dir_op_e;

	typedef struct packed {
		dir_op_e     op;
		cfg_index_t  idx;
		logic [11:0] data;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        typed;
		logic [10:0] erow;
		logic [10:0] ecol;
	} dir_row_t;

	typedef enum {RX_STREAM, RX_COIN, RX_CHOKE} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  pix_red;
	logic [7:0]  pix_green;
	logic [7:0]  pix_blue;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] out_row;
	logic [10:0] out_col;
	logic [7:0]  res_red;
	logic [7:0]  res_green;
	logic [7:0]  res_blue;
	logic        last_of_run;

	// Predictor state.
	logic [11:0]  width_reg;
	logic [11:0]  height_reg;
	filter_code_t kernel_reg;
	bit [23:0]    row_above2 [FRAME_MAX];
	bit [23:0]    row_above1 [FRAME_MAX];
	bit [23:0]    window [9];
	int unsigned  cur_row;
	int unsigned  cur_col;

	out_pixel_t filtered_due [$];
	dir_row_t   directed [$];
	int         mismatches = 0;
	int         burst_left = 0;
	int         stall_left = 0;
	rx_mode_e   rx_mode = RX_STREAM;

	conv3x3_image_filter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pix_red     (pix_red),
		.pix_green   (pix_green),
		.pix_blue    (pix_blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_col     (out_col),
		.res_red     (res_red),
		.res_green   (res_green),
		.res_blue    (res_blue),
		.last_of_run (last_of_run)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Fail the run if it hangs.
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("conv3x3_image_filter regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string line);
		mismatches++;
		if (mismatches <= 50)
			$display("%s", line);
	endtask

	task automatic check_field(input string name, input logic [10:0] got,
			input logic [10:0] want, input out_pixel_t at);
		if (got !== want)
			report_mismatch($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
				name, at.row, at.col, got, want));
	endtask

	// Size registers act as 3 below 3 and saturate at the frame maximum.
	function automatic int unsigned frame_dim(input logic [11:0] v);
		if (v < 3)
			return 3;
		if (v > FRAME_MAX)
			return FRAME_MAX;
		return int'(v);
	endfunction

	// Weight of one window tap for the given kernel; unknown codes behave as identity.
	function automatic int tap_weight(input filter_code_t k, input tap_t t);
		case (k)
			FILT_SMOOTH: return K_NINTH;
			FILT_BLUR: begin
				if (t == TAP_C)
					return K_QUARTER;
				if (t == TAP_NW || t == TAP_NE || t == TAP_SW || t == TAP_SE)
					return K_SIXTEENTH;
				return K_EIGHTH;
			end
			FILT_SHARPEN: begin
				if (t == TAP_C)
					return K_ELEVEN_3RD;
				if (t == TAP_N || t == TAP_W || t == TAP_E || t == TAP_S)
					return -K_TWO_THIRDS;
				return 0;
			end
			FILT_MEAN: return (t == TAP_C) ? K_NINE : -K_UNIT;
			FILT_EMBOSS: begin
				if (t == TAP_N)
					return K_UNIT;
				if (t == TAP_S)
					return -K_UNIT;
				return 0;
			end
			default: return (t == TAP_C) ? K_UNIT : 0;
		endcase
	endfunction

	// One colour lane through the kernel, with rounding down of the fraction and saturation.
	function automatic logic [7:0] convolve_lane(input int lane);
		int sum;
		sum = 0;
		for (int i = 0; i < 9; i++)
			sum += int'(window[i][lane*8 +: 8]) * tap_weight(kernel_reg, tap_t'(i));
		if (sum <= 0)
			return 8'd0;
		sum = sum >>> K_FRAC;
		if (sum > 255)
			return 8'd255;
		return 8'(sum);
	endfunction

	// Advance the predictor by one pixel and queue the results it gives; returns their number.
	function automatic int convolve_pixel(input logic [23:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		bit [23:0]   above2;
		bit [23:0]   above1;
		bit          border;
		out_pixel_t  res;
		int          n;
		w = frame_dim(width_reg);
		h = frame_dim(height_reg);
		r = cur_row;
		c = cur_col;
		if (c >= w)
			c = 0;
		if (r >= h)
			r = 0;
		above2 = row_above2[c];
		above1 = row_above1[c];
		row_above2[c] = above1;
		row_above1[c] = px;
		for (int i = 0; i < 3; i++) begin
			window[i*3] = window[i*3+1];
			window[i*3+1] = window[i*3+2];
		end
		window[2] = above2;
		window[5] = above1;
		window[8] = px;
		border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		n = 0;
		// The interior pixel one up and one left is complete once this pixel is in.
		if (r >= 2 && c >= 2) begin
			res.row = 11'(r - 1);
			res.col = 11'(c - 1);
			res.red = convolve_lane(0);
			res.green = convolve_lane(1);
			res.blue = convolve_lane(2);
			res.last = !border;
			filtered_due.push_back(res);
			n++;
		end
		// Pixels on the outer frame are copied straight through.
		if (border) begin
			res.row = 11'(r);
			res.col = 11'(c);
			res.red = px[7:0];
			res.green = px[15:8];
			res.blue = px[23:16];
			res.last = 1'b1;
			filtered_due.push_back(res);
			n++;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		cur_row = r;
		cur_col = c;
		return n;
	endfunction

	// Lane values lean towards the extremes so that sums saturate and go negative often.
	function automatic logic [7:0] pick_lane();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_reg(input cfg_index_t idx, input logic [11:0] data);
		dir_row_t e;
		e = '0;
		e.op = DIR_WRITE;
		e.idx = idx;
		e.data = data;
		directed.push_back(e);
	endfunction

	function automatic void add_pix(input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue, input logic typed);
		dir_row_t e;
		e = '0;
		e.op = DIR_PIXEL;
		e.red = red;
		e.green = green;
		e.blue = blue;
		e.typed = typed;
		directed.push_back(e);
	endfunction

	// Register write at a falling edge; the predictor follows at the next rising edge.
	task automatic program_reg(input cfg_index_t idx, input logic [11:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_IMAGE_WIDTH: begin
				width_reg = data;
				cur_row = 0;
				cur_col = 0;
			end
			CFG_IMAGE_HEIGHT: begin
				height_reg = data;
				cur_row = 0;
				cur_col = 0;
			end
			CFG_FILTER_SELECT: kernel_reg = filter_code_t'(data[2:0]);
			default: ;
		endcase
	endtask

	task automatic release_cfg();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stop sending, wait for every queued result, then let the pipeline run empty.
	task automatic settle_pipeline();
		int waited;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (filtered_due.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (filtered_due.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				filtered_due.size()));
			filtered_due.delete();
		end
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// Offer one item in bursts with random gaps; a typed row replaces the predicted results with a copy at the origin.
	task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue, input logic typed);
		int         gap;
		int         n;
		out_pixel_t copy;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pix_red <= red;
		pix_green <= green;
		pix_blue <= blue;
		burst_left--;
		do
			@(posedge clk);
		while (!in_ready);
		n = convolve_pixel({blue, green, red});
		if (typed) begin
			repeat (n) void'(filtered_due.pop_back());
			copy.row = 11'd0;
			copy.col = 11'd0;
			copy.red = red;
			copy.green = green;
			copy.blue = blue;
			copy.last = 1'b1;
			filtered_due.push_back(copy);
		end
	endtask

	// Receiver readiness changes between streaming, coin-toss and heavy stalling.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 2));
			stall_left = $urandom_range(10, 80);
		end
		stall_left--;
		case (rx_mode)
			RX_STREAM: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Each result taken is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		out_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (filtered_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result at row %0d col %0d",
					out_row, out_col));
			end else begin
				want = filtered_due.pop_front();
				check_field("row", out_row, want.row, want);
				check_field("col", out_col, want.col, want);
				check_field("red", res_red, want.red, want);
				check_field("green", res_green, want.green, want);
				check_field("blue", res_blue, want.blue, want);
				check_field("last", last_of_run, want.last, want);
			end
		end
	end

	// Stimulus: directed table, wide frame, tall frame, then random frames.
	initial begin : stimulus
		int           k;
		int           r;
		int           c;
		int           count;
		int           pause_at;
		int           random_items;
		int           kind;
		bit           wr_w;
		bit           wr_h;
		bit           prev_write;
		logic [7:0]   red;
		int unsigned  w;
		int unsigned  h;
		dir_row_t     row_e;
		filter_code_t row_kernel [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = 12'd0;
		in_valid = 1'b0;
		pix_red = 8'd0;
		pix_green = 8'd0;
		pix_blue = 8'd0;
		width_reg = 12'(RESET_WIDTH);
		height_reg = 12'(RESET_HEIGHT);
		kernel_reg = FILT_IDENTITY;
		cur_row = 0;
		cur_col = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. After reset the first pixel is a plain copy at the origin.
		add_pix(8'hff, 8'h00, 8'h5a, 1'b1);
		// A width below the minimum acts as 3, a height above the maximum as the maximum.
		add_reg(CFG_IMAGE_WIDTH, 12'd0);
		add_reg(CFG_IMAGE_HEIGHT, 12'hfff);
		add_reg(CFG_UNUSED, 12'hfff);
		add_reg(CFG_FILTER_SELECT, {9'd0, FILT_IDENTITY});
		// Checkerboard in red and green, striped blue; one kernel per row from row 2.
		row_kernel = '{FILT_SMOOTH, FILT_BLUR, FILT_SHARPEN, FILT_MEAN, FILT_EMBOSS,
			FILT_SPARE_LO};
		for (r = 0; r < 8; r++) begin
			if (r >= 2)
				add_reg(CFG_FILTER_SELECT, {9'd0, row_kernel[r-2]});
			for (c = 0; c < 3; c++) begin
				red = ((r + c) % 2 != 0) ? 8'd255 : 8'd0;
				add_pix(red, ~red, (r % 2 != 0) ? 8'd0 : 8'd255, r == 0 && c == 0);
			end
		end
		prev_write = 1'b0;
		for (k = 0; k < directed.size(); k++) begin
			row_e = directed[k];
			if (row_e.op == DIR_WRITE) begin
				if (!prev_write)
					settle_pipeline();
				program_reg(row_e.idx, row_e.data);
				prev_write = 1'b1;
			end else begin
				if (prev_write)
					release_cfg();
				send_pixel(row_e.red, row_e.green, row_e.blue, row_e.typed);
				prev_write = 1'b0;
			end
		end

		// Widest frame: the start of its top row.
		settle_pipeline();
		program_reg(CFG_IMAGE_WIDTH, 12'hfff);
		program_reg(CFG_IMAGE_HEIGHT, 12'd3);
		program_reg(CFG_FILTER_SELECT, {9'd0, FILT_SHARPEN});
		release_cfg();
		for (k = 0; k < WIDE_ITEMS; k++)
			send_pixel(pick_lane(), pick_lane(), pick_lane(), 1'b0);

		// Tallest frame: its first rows.
		settle_pipeline();
		program_reg(CFG_IMAGE_WIDTH, 12'd3);
		program_reg(CFG_IMAGE_HEIGHT, 12'(FRAME_MAX));
		program_reg(CFG_FILTER_SELECT, {9'h1ff, FILT_BLUR});
		release_cfg();
		for (k = 0; k < TALL_ITEMS; k++)
			send_pixel(pick_lane(), pick_lane(), pick_lane(), 1'b0);

		// Random small frames: whole, doubled or cut short, with kernel changes mid-frame.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle_pipeline();
			kind = $urandom_range(0, 4);
			if (kind == 0) begin
				program_reg(CFG_FILTER_SELECT,
					{9'($urandom), filter_code_t'($urandom_range(0, 7))});
				count = $urandom_range(3, 20);
			end else begin
				wr_w = ($urandom_range(0, 3) != 0);
				wr_h = !wr_w || ($urandom_range(0, 1) == 1);
				if (wr_w)
					program_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 5) == 0) ?
						12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8)));
				if (wr_h)
					program_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 5) == 0) ?
						12'($urandom_range(0, 2)) : 12'($urandom_range(3, 6)));
				if ($urandom_range(0, 2) != 0)
					program_reg(CFG_FILTER_SELECT,
						{9'($urandom), filter_code_t'($urandom_range(0, 7))});
				if ($urandom_range(0, 3) == 0)
					program_reg(CFG_UNUSED, 12'($urandom));
				w = frame_dim(width_reg);
				h = frame_dim(height_reg);
				if ($urandom_range(0, 2) == 0)
					count = $urandom_range(1, w * h - 1);
				else
					count = w * h * $urandom_range(1, 2);
			end
			release_cfg();
			pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
			for (k = 0; k < count; k++) begin
				if (k == pause_at)
					settle_pipeline();
				send_pixel(pick_lane(), pick_lane(), pick_lane(), 1'b0);
			end
			random_items += count;
		end

		settle_pipeline();
		if (mismatches == 0)
			$display("conv3x3_image_filter regression: pass");
		else
			$display("conv3x3_image_filter regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/c3f_pkg.sv
hw/rtl/conv3x3_image_filter.sv
verif/conv3x3_image_filter_tb.sv
